[rtl/core/positional_array_list_macros.svh]
// Assertion macros for the positional array list core.
// Included by the top level only; no other dependencies.
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH
`ifndef SYNTHESIS
`define PAL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pal assertion failed");
`define PAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pal assertion failed");
`else
`define PAL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PAL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/pal_pkg.sv]
// Shared types and constants for the positional array list core.
// Used by the controller, the datapath and the top level.
`default_nettype none
package pal_pkg;

    localparam int SLOTS   = 16;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LEN_W   = ($clog2(SLOTS + 1) > 5) ? $clog2(SLOTS + 1) : 5;
    localparam int POS_W   = 8;
    localparam int CMP_W   = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam int WORD_W  = 32;
    localparam int OUTLEN_W = 5;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_REAR  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_UPD_AT    = 3'd3,
        OP_RD_AT     = 3'd4,
        OP_DEL_FRONT = 3'd5,
        OP_DEL_REAR  = 3'd6,
        OP_DEL_AT    = 3'd7
    } t_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage
`default_nettype wire

[rtl/core/pal_ctrl.sv]
// Controller for the positional array list core.
// Depends on pal_pkg for the state and command types.
`default_nettype none
module pal_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    output logic              o_busy,
    output pal_pkg::t_cmd     o_cmd
);
    import pal_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_busy     = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_busy     = 1'b1;
                o_cmd.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/pal_dpath.sv]
// Datapath for the positional array list core: slot cells, length and result registers.
// Depends on pal_pkg for sizes, the operation codes and the command struct.
`default_nettype none
module pal_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pal_pkg::t_cmd                 i_cmd,
    input  wire logic [2:0]                    i_op,
    input  wire logic signed [pal_pkg::WORD_W-1:0] i_value_in,
    input  wire logic [pal_pkg::POS_W-1:0]     i_position,
    output logic                               o_valid,
    output logic signed [pal_pkg::WORD_W-1:0]  o_read_value,
    output logic                               o_done_ok,
    output logic [pal_pkg::OUTLEN_W-1:0]       o_length_now,
    output logic                               o_is_full,
    output logic                               o_is_empty
);
    import pal_pkg::*;

    t_op                 r_op;
    logic [WORD_W-1:0]   r_value;
    logic [POS_W-1:0]    r_pos;
    logic [WORD_W-1:0]   r_slot [SLOTS];
    logic [WORD_W-1:0]   n_slot [SLOTS];
    logic [WORD_W-1:0]   up_src [SLOTS];
    logic [WORD_W-1:0]   dn_src [SLOTS];
    logic [LEN_W-1:0]    r_len;
    logic [LEN_W-1:0]    n_len;
    logic [WORD_W-1:0]   r_rd;
    logic [WORD_W-1:0]   n_rd;
    logic                r_ok;
    logic                n_ok;
    logic                r_valid;

    logic [CMP_W-1:0]    len_c;
    logic [CMP_W-1:0]    pos_c;
    logic [CMP_W-1:0]    at;
    logic                ins_en;
    logic                del_en;
    logic                upd_en;

    // Each cell sees its lower and upper neighbor for the up and down shifts.
    for (genvar g = 0; g < SLOTS; g++) begin : g_nbr
        if (g > 0) begin : g_up
            assign up_src[g] = r_slot[g-1];
        end else begin : g_up0
            assign up_src[g] = r_slot[g];
        end
        if (g < SLOTS - 1) begin : g_dn
            assign dn_src[g] = r_slot[g+1];
        end else begin : g_dnl
            assign dn_src[g] = r_slot[g];
        end
    end

    always_comb begin
        len_c  = CMP_W'(r_len);
        pos_c  = CMP_W'(r_pos);
        at     = '0;
        ins_en = 1'b0;
        del_en = 1'b0;
        upd_en = 1'b0;
        n_rd   = '1;
        unique case (r_op)
            OP_INS_FRONT: begin
                at     = '0;
                ins_en = (len_c < CMP_W'(SLOTS));
            end
            OP_INS_REAR: begin
                at     = len_c;
                ins_en = (len_c < CMP_W'(SLOTS));
            end
            OP_INS_AT: begin
                at     = (pos_c > len_c) ? len_c : pos_c;
                ins_en = (len_c < CMP_W'(SLOTS));
            end
            OP_UPD_AT: begin
                at     = pos_c;
                upd_en = (pos_c < len_c);
            end
            OP_RD_AT: begin
                at = pos_c;
                if (pos_c < len_c) begin
                    n_rd = r_slot[r_pos[IDX_W-1:0]];
                end
            end
            OP_DEL_FRONT: begin
                at     = '0;
                del_en = (len_c != '0);
            end
            OP_DEL_REAR: begin
                // Wraps on an empty list, but the delete is refused then.
                at     = len_c - CMP_W'(1);
                del_en = (len_c != '0);
            end
            OP_DEL_AT: begin
                at     = pos_c;
                del_en = (len_c != '0) && (pos_c < len_c);
            end
            default: begin
                at = '0;
            end
        endcase
        n_ok = ins_en || del_en || upd_en || ((r_op == OP_RD_AT) && (pos_c < len_c));

        n_len = r_len;
        if (ins_en) begin
            n_len = r_len + LEN_W'(1);
        end else if (del_en) begin
            n_len = r_len - LEN_W'(1);
        end

        for (int i = 0; i < SLOTS; i++) begin
            n_slot[i] = r_slot[i];
            if (ins_en) begin
                if (CMP_W'(i) == at) begin
                    n_slot[i] = r_value;
                end else if ((CMP_W'(i) > at) && (CMP_W'(i) <= len_c)) begin
                    n_slot[i] = up_src[i];
                end
            end else if (del_en) begin
                if ((CMP_W'(i) >= at) && (CMP_W'(i + 1) < len_c)) begin
                    n_slot[i] = dn_src[i];
                end
            end else if (upd_en && (CMP_W'(i) == at)) begin
                n_slot[i] = r_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_op);
            r_value <= i_value_in;
            r_pos   <= i_position;
        end
        if (i_cmd.exec) begin
            r_slot <= n_slot;
            r_rd   <= n_rd;
            r_ok   <= n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_len <= n_len;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_read_value = r_rd;
    assign o_done_ok    = r_ok;
    assign o_length_now = r_len[OUTLEN_W-1:0];
    assign o_is_full    = (r_len == LEN_W'(SLOTS));
    assign o_is_empty   = (r_len == '0);

endmodule
`default_nettype wire

[rtl/core/positional_array_list.sv]
// Top level of the positional array list core: a bounded ordered list of
// signed 32-bit words with insert, update, read and delete at a position.
// Depends on pal_pkg, pal_ctrl, pal_dpath and positional_array_list_macros.svh.
//
// Commands: drive i_op, i_value_in and i_position with start high; the item
// is taken at a rising edge where busy is low. busy is high for one cycle
// while the operation is applied to all slot cells at once.
// Results: o_valid is high for exactly one cycle, registered from the execute
// step, with o_read_value, o_done_ok, o_length_now, o_is_full and
// o_is_empty. The receiver cannot stall; each result must be taken then.
// An item's command is captured first, then the slot cells are updated; no
// new item is taken while busy is high. A new item can be accepted in the
// same cycle as the previous result is shown.
// Reset (synchronous, active low) empties the list and clears the control
// state; slot contents are not cleared and are only read after being written.
`default_nettype none
`include "positional_array_list_macros.svh"
module positional_array_list (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [2:0]                        i_op,
    input  wire logic signed [pal_pkg::WORD_W-1:0] i_value_in,
    input  wire logic [pal_pkg::POS_W-1:0]         i_position,
    output logic                                   o_valid,
    output logic signed [pal_pkg::WORD_W-1:0]      o_read_value,
    output logic                                   o_done_ok,
    output logic [pal_pkg::OUTLEN_W-1:0]           o_length_now,
    output logic                                   o_is_full,
    output logic                                   o_is_empty
);
    import pal_pkg::*;

    t_cmd cmd;

    pal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    pal_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (i_op),
        .i_value_in   (i_value_in),
        .i_position   (i_position),
        .o_valid      (o_valid),
        .o_read_value (o_read_value),
        .o_done_ok    (o_done_ok),
        .o_length_now (o_length_now),
        .o_is_full    (o_is_full),
        .o_is_empty   (o_is_empty)
    );

    // A result only follows the execute cycle.
    `PAL_ASSERT_NOW(a_valid_after_exec, i_clk, i_rst_n, o_valid, $past(busy))
    // An accepted item always enters the execute cycle, which lasts one cycle.
    `PAL_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, start && !busy, busy)
    `PAL_ASSERT_NEXT(a_exec_one_cycle, i_clk, i_rst_n, busy, !busy && o_valid)
    // A refused operation leaves the length unchanged.
    `PAL_ASSERT_NOW(a_refused_keeps_len, i_clk, i_rst_n, o_valid && !o_done_ok,
        o_length_now == $past(o_length_now, 2))

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for positional_array_list: drives list commands and
// checks every result against an in-bench list predictor. Depends on pal_pkg.
`timescale 1ns / 100ps
module tb_top;
    import pal_pkg::*;

    typedef struct {
        logic [WORD_W-1:0]   read_value;
        logic                done_ok;
        logic [OUTLEN_W-1:0] length_now;
        logic                is_full;
        logic                is_empty;
    } t_list_result;

    class list_scoreboard;
        logic [WORD_W-1:0] slot_words [SLOTS];
        int unsigned       count;
        t_list_result      pending [$];
        int                errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function bit insert_word(int unsigned at, logic [WORD_W-1:0] word);
            int unsigned idx;
            if (count >= SLOTS) return 1'b0;
            if (at > count) at = count;
            for (idx = count; idx > at; idx--) slot_words[idx] = slot_words[idx - 1];
            slot_words[at] = word;
            count++;
            return 1'b1;
        endfunction

        function bit remove_word(int unsigned at);
            int unsigned idx;
            if (count == 0 || at >= count) return 1'b0;
            for (idx = at; idx + 1 < count; idx++) slot_words[idx] = slot_words[idx + 1];
            count--;
            return 1'b1;
        endfunction

        // Applies one accepted item to the predicted list and queues its result.
        function void note_command(t_op op, logic [WORD_W-1:0] word, logic [POS_W-1:0] pos);
            t_list_result r;
            bit           ok;
            r.read_value = '1;
            ok = 1'b0;
            case (op)
                OP_INS_FRONT: ok = insert_word(0, word);
                OP_INS_REAR:  ok = insert_word(count, word);
                OP_INS_AT:    ok = insert_word(pos, word);
                OP_UPD_AT: begin
                    if (pos < count) begin
                        slot_words[pos] = word;
                        ok = 1'b1;
                    end
                end
                OP_RD_AT: begin
                    if (pos < count) begin
                        r.read_value = slot_words[pos];
                        ok = 1'b1;
                    end
                end
                OP_DEL_FRONT: ok = remove_word(0);
                OP_DEL_REAR:  ok = (count > 0) ? remove_word(count - 1) : 1'b0;
                default:      ok = remove_word(pos);
            endcase
            r.done_ok    = ok;
            r.length_now = count[OUTLEN_W-1:0];
            r.is_full    = (count == SLOTS);
            r.is_empty   = (count == 0);
            pending.push_back(r);
        endfunction

        function void check_result(t_list_result got);
            t_list_result want;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected, read_value %h", $time,
                         got.read_value);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.read_value !== want.read_value) begin
                $display("%0t: read_value expected %h actual %h", $time,
                         want.read_value, got.read_value);
                errors++;
            end
            if (got.done_ok !== want.done_ok) begin
                $display("%0t: done_ok expected %b actual %b", $time,
                         want.done_ok, got.done_ok);
                errors++;
            end
            if (got.length_now !== want.length_now) begin
                $display("%0t: length_now expected %0d actual %0d", $time,
                         want.length_now, got.length_now);
                errors++;
            end
            if (got.is_full !== want.is_full) begin
                $display("%0t: is_full expected %b actual %b", $time,
                         want.is_full, got.is_full);
                errors++;
            end
            if (got.is_empty !== want.is_empty) begin
                $display("%0t: is_empty expected %b actual %b", $time,
                         want.is_empty, got.is_empty);
                errors++;
            end
        endfunction
    endclass

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [2:0]                   i_op = 3'd0;
    logic signed [WORD_W-1:0]     i_value_in = '0;
    logic [POS_W-1:0]             i_position = '0;
    logic                         o_valid;
    logic signed [WORD_W-1:0]     o_read_value;
    logic                         o_done_ok;
    logic [OUTLEN_W-1:0]          o_length_now;
    logic                         o_is_full;
    logic                         o_is_empty;

    list_scoreboard scoreboard = new();

    positional_array_list u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_value_in   (i_value_in),
        .i_position   (i_position),
        .o_valid      (o_valid),
        .o_read_value (o_read_value),
        .o_done_ok    (o_done_ok),
        .o_length_now (o_length_now),
        .o_is_full    (o_is_full),
        .o_is_empty   (o_is_empty)
    );

    always #6 i_clk = ~i_clk;

    // Results are checked before the item taken at the same edge is noted,
    // so the queue order always follows acceptance order.
    always @(posedge i_clk) begin
        t_list_result got;
        if (i_rst_n) begin
            if (o_valid) begin
                got.read_value = o_read_value;
                got.done_ok    = o_done_ok;
                got.length_now = o_length_now;
                got.is_full    = o_is_full;
                got.is_empty   = o_is_empty;
                scoreboard.check_result(got);
            end
            if (start && !busy) scoreboard.note_command(t_op'(i_op), i_value_in, i_position);
        end
    end

    // Holds the item on the command ports until the edge that takes it.
    task automatic send_item(t_op op, logic [WORD_W-1:0] word, logic [POS_W-1:0] pos);
        start      <= 1'b1;
        i_op       <= op;
        i_value_in <= word;
        i_position <= pos;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic maybe_idle(int pct);
        if ($urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int n;
        n = scoreboard.count;
        case ($urandom_range(0, 19))
            0, 1, 2: return POS_W'(n - 1);
            3, 4:    return POS_W'(n);
            5, 6, 7: return POS_W'($urandom_range(0, 255));
            default: return POS_W'($urandom_range(0, n));
        endcase
    endfunction

    // Mode 0 leans to inserts and fills the list, mode 1 leans to deletes and
    // drains it, mode 2 mostly reads and updates what is there.
    function automatic t_op pick_op(int mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            0: begin
                if (roll < 65) return t_op'($urandom_range(0, 2));
                if (roll < 85) return t_op'($urandom_range(3, 4));
                return t_op'($urandom_range(5, 7));
            end
            1: begin
                if (roll < 60) return t_op'($urandom_range(5, 7));
                if (roll < 80) return t_op'($urandom_range(3, 4));
                return t_op'($urandom_range(0, 2));
            end
            default: begin
                if (roll < 50) return t_op'($urandom_range(3, 4));
                return t_op'($urandom_range(0, 7));
            end
        endcase
    endfunction

    initial begin
        int idle_pct [3] = '{18, 55, 0};
        int mode;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Deletes, read and update on an empty list are all refused.
        send_item(OP_DEL_FRONT, 32'h1111_1111, 8'd0);
        send_item(OP_DEL_REAR,  32'h2222_2222, 8'd0);
        send_item(OP_DEL_AT,    32'h3333_3333, 8'd0);
        send_item(OP_RD_AT,     32'h4444_4444, 8'd0);
        send_item(OP_UPD_AT,    32'h5555_5555, 8'd0);
        // Inserts, including one far past the length that lands at the rear, then reads, updates and deletes.
        send_item(OP_INS_FRONT, 32'h7FFF_FFFF, 8'd0);
        send_item(OP_INS_REAR,  32'h8000_0000, 8'd0);
        send_item(OP_INS_AT,    32'hFFFF_FFFF, 8'd255);
        send_item(OP_INS_AT,    32'h0000_0000, 8'd1);
        send_item(OP_INS_AT,    32'h1234_5678, 8'd0);
        send_item(OP_RD_AT,     32'h0000_0000, 8'd0);
        send_item(OP_RD_AT,     32'h0000_0000, 8'd4);
        send_item(OP_RD_AT,     32'h0000_0000, 8'd5);
        send_item(OP_RD_AT,     32'h0000_0000, 8'd255);
        send_item(OP_UPD_AT,    32'hA5A5_A5A5, 8'd4);
        send_item(OP_UPD_AT,    32'h5A5A_5A5A, 8'd5);
        send_item(OP_UPD_AT,    32'h5A5A_5A5A, 8'd255);
        send_item(OP_DEL_AT,    32'h0000_0000, 8'd255);
        send_item(OP_DEL_AT,    32'h0000_0000, 8'd2);
        send_item(OP_DEL_REAR,  32'h0000_0000, 8'd0);
        send_item(OP_DEL_FRONT, 32'h0000_0000, 8'd0);
        send_item(OP_RD_AT,     32'h0000_0000, 8'd1);

        for (int phase = 0; phase < 3; phase++) begin
            mode = 0;
            for (int k = 0; k < 644; k++) begin
                if (k % 32 == 0) mode = $urandom_range(0, 2);
                maybe_idle(idle_pct[phase]);
                send_item(pick_op(mode), pick_word(), pick_position());
            end
        end
        start <= 1'b0;

        while (scoreboard.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (scoreboard.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
